### src/timed_event_queue_defines.svh
// ----------------------------------------------------------------------------
// timed_event_queue_defines.svh
// Assertion macros shared by the timed event queue RTL.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TEQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define TEQ_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Commands, states and fixed widths of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REM_H  = 3'd1,
        CMD_REM_HD = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_TICK   = 3'd4,
        CMD_PAUSE  = 3'd5,
        CMD_RESUME = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    localparam int TIME_W   = 32;
    localparam int DATA_W   = 32;
    localparam int PORT_H_W = 16;
    localparam int DELAY_W  = 31;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 88;
    localparam logic [3:0] PAUSE_MAX = 4'd15;

endpackage

### src/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// Sorted queue of timed entries held in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: request fields
// m_*      out  m_tvalid/m_tready  tuser: kind; tdata: result; tlast: last
//
// A request that walks the store (add, remove, find, tick, final resume)
// goes from acceptance through one memory read per entry, pipelined, then a
// drain step, a finish step and the reply before the next acceptance.
// Pause, resume without a walk, clear and a full add go from acceptance
// straight to the reply.
// Reset clears the count and pause state; the store needs no clearing pass.
// Output back-pressure stalls a tick walk when a second fired entry meets a
// full output register, and holds every request in its reply cycle until the
// output register is free.
// ----------------------------------------------------------------------------
`include "timed_event_queue_defines.svh"

module timed_event_queue #(
    parameter int DEPTH       = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0: event_time, handle, user_data, always_flag, now
    input  logic [teq_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: cmd
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0: out_handle, out_data, found, delay, full_res
    output logic [teq_pkg::M_DATA_W-1:0]   m_tdata,
    // tuser: kind
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int HB = HANDLE_BITS;
    localparam int EW = teq_pkg::TIME_W + HB + teq_pkg::DATA_W + 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    // Input fields.
    logic [31:0] in_time, in_data, in_now;
    logic [15:0] in_handle;
    logic        in_alw;
    teq_pkg::cmd_t in_cmd;

    assign in_time   = s_tdata[31:0];
    assign in_handle = s_tdata[47:32];
    assign in_data   = s_tdata[79:48];
    assign in_alw    = s_tdata[80];
    assign in_now    = s_tdata[112:81];
    assign in_cmd    = teq_pkg::cmd_t'(s_tuser);

    teq_pkg::state_t state_reg, state_next;
    teq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]     time_reg, time_next;
    logic [HB-1:0]   hnd_reg, hnd_next;
    logic [31:0]     data_reg, data_next;
    logic            alw_reg, alw_next;
    logic [31:0]     aux_reg, aux_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [3:0]      depth_reg, depth_next;
    logic [31:0]     paused_at_reg, paused_at_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            proc_valid_reg, proc_valid_next;
    logic [IW-1:0]   proc_idx_reg, proc_idx_next;
    logic [CW-1:0]   wr_idx_reg, wr_idx_next;
    logic            hit_reg, hit_next;
    logic [30:0]     delay_reg, delay_next;
    logic            full_reg, full_next;
    logic [EW-1:0]   carry_reg, carry_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [HB-1:0]   pend_h_reg, pend_h_next;
    logic [31:0]     pend_d_reg, pend_d_next;

    logic            m_tvalid_reg;
    logic            m_kind_reg, m_last_reg;
    logic [teq_pkg::M_DATA_W-1:0] m_tdata_reg;

    teq_pkg::ram_ctl_t ram_ctl;
    logic [IW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;

    logic            out_load, out_kind, out_last, out_found, out_full;
    logic [HB-1:0]   out_h;
    logic [31:0]     out_h32, out_d;
    logic [30:0]     out_delay;
    logic            out_free;

    logic [31:0]     e_time, e_data, diff, span;
    logic [HB-1:0]   e_hnd;
    logic            e_alw, due, fired, stall, match;

    assign e_time = rdata[31:0];
    assign e_hnd  = rdata[32 +: HB];
    assign e_data = rdata[32 + HB +: 32];
    assign e_alw  = rdata[EW-1];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == teq_pkg::ST_IDLE);

    assign due   = !(aux_reg < e_time);
    assign fired = proc_valid_reg && (cmd_reg == teq_pkg::CMD_TICK) && !hit_reg && due
                   && ((depth_reg == 4'd0) || e_alw);
    assign stall = fired && pend_valid_reg && !out_free;
    assign match = (e_hnd == hnd_reg)
                   && ((cmd_reg != teq_pkg::CMD_REM_HD) || (e_data == data_reg));
    assign diff  = e_time - aux_reg;
    assign span  = in_now - paused_at_reg;

    teq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        time_next       = time_reg;
        hnd_next        = hnd_reg;
        data_next       = data_reg;
        alw_next        = alw_reg;
        aux_next        = aux_reg;
        count_next      = count_reg;
        depth_next      = depth_reg;
        paused_at_next  = paused_at_reg;
        rd_idx_next     = rd_idx_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        wr_idx_next     = wr_idx_reg;
        hit_next        = hit_reg;
        delay_next      = delay_reg;
        full_next       = full_reg;
        carry_next      = carry_reg;
        pend_valid_next = pend_valid_reg;
        pend_h_next     = pend_h_reg;
        pend_d_next     = pend_d_reg;
        ram_ctl         = '0;
        waddr           = '0;
        wdata           = '0;
        raddr           = rd_idx_reg[IW-1:0];
        out_load        = 1'b0;
        out_kind        = 1'b1;
        out_last        = 1'b1;
        out_h           = '0;
        out_d           = '0;
        out_found       = 1'b0;
        out_delay       = '0;
        out_full        = 1'b0;

        case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = in_cmd;
                    time_next       = in_time;
                    hnd_next        = HB'(32'(in_handle));
                    data_next       = in_data;
                    alw_next        = in_alw;
                    aux_next        = in_now;
                    rd_idx_next     = '0;
                    proc_valid_next = 1'b0;
                    wr_idx_next     = '0;
                    hit_next        = 1'b0;
                    delay_next      = '0;
                    full_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = teq_pkg::ST_DONE;
                    case (in_cmd)
                        teq_pkg::CMD_ADD:
                        begin
                            if (count_reg >= COUNT_MAX)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                // A paused, non-always entry is pulled back by the paused span.
                                if ((depth_reg != 4'd0) && !in_alw)
                                begin
                                    time_next = in_time - span;
                                end
                                state_next = teq_pkg::ST_WALK;
                            end
                        end
                        teq_pkg::CMD_REM_H, teq_pkg::CMD_REM_HD, teq_pkg::CMD_TICK:
                        begin
                            state_next = teq_pkg::ST_WALK;
                        end
                        teq_pkg::CMD_FIND:
                        begin
                            aux_next   = (depth_reg != 4'd0) ? paused_at_reg : in_now;
                            state_next = teq_pkg::ST_WALK;
                        end
                        teq_pkg::CMD_PAUSE:
                        begin
                            if (depth_reg == 4'd0)
                            begin
                                paused_at_next = in_now;
                            end
                            if (depth_reg < teq_pkg::PAUSE_MAX)
                            begin
                                depth_next = depth_reg + 4'd1;
                            end
                        end
                        teq_pkg::CMD_RESUME:
                        begin
                            if (depth_reg != 4'd0)
                            begin
                                depth_next = depth_reg - 4'd1;
                                if (depth_reg == 4'd1)
                                begin
                                    paused_at_next = '0;
                                    if (!span[31])
                                    begin
                                        aux_next   = span;
                                        state_next = teq_pkg::ST_WALK;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end

            teq_pkg::ST_WALK:
            begin
                if (!stall)
                begin
                    if (proc_valid_reg)
                    begin
                        case (cmd_reg)
                            teq_pkg::CMD_ADD:
                            begin
                                // Once the new entry is placed, every later entry moves up one.
                                if (hit_reg)
                                begin
                                    ram_ctl.wr_en = 1'b1;
                                    waddr         = proc_idx_reg;
                                    wdata         = carry_reg;
                                    carry_next    = rdata;
                                end
                                else if (time_reg < e_time)
                                begin
                                    ram_ctl.wr_en = 1'b1;
                                    waddr         = proc_idx_reg;
                                    wdata         = {alw_reg, data_reg, hnd_reg, time_reg};
                                    carry_next    = rdata;
                                    hit_next      = 1'b1;
                                end
                            end
                            teq_pkg::CMD_REM_H, teq_pkg::CMD_REM_HD:
                            begin
                                if (match && !hit_reg)
                                begin
                                    hit_next = 1'b1;
                                end
                                else
                                begin
                                    ram_ctl.wr_en = 1'b1;
                                    waddr         = wr_idx_reg[IW-1:0];
                                    wdata         = rdata;
                                    wr_idx_next   = wr_idx_reg + CW'(1);
                                end
                            end
                            teq_pkg::CMD_FIND:
                            begin
                                if (!hit_reg && (e_hnd == hnd_reg))
                                begin
                                    hit_next   = 1'b1;
                                    delay_next = diff[31] ? 31'd0 : diff[30:0];
                                end
                            end
                            teq_pkg::CMD_TICK:
                            begin
                                if (fired)
                                begin
                                    // The previous fired entry goes out; the newest is held
                                    // back until it is known whether it is the last.
                                    if (pend_valid_reg)
                                    begin
                                        out_load = 1'b1;
                                        out_kind = 1'b0;
                                        out_last = 1'b0;
                                        out_h    = pend_h_reg;
                                        out_d    = pend_d_reg;
                                    end
                                    pend_valid_next = 1'b1;
                                    pend_h_next     = e_hnd;
                                    pend_d_next     = e_data;
                                end
                                else
                                begin
                                    ram_ctl.wr_en = 1'b1;
                                    waddr         = wr_idx_reg[IW-1:0];
                                    wdata         = rdata;
                                    wr_idx_next   = wr_idx_reg + CW'(1);
                                    if (!due)
                                    begin
                                        hit_next = 1'b1;
                                    end
                                end
                            end
                            teq_pkg::CMD_RESUME:
                            begin
                                ram_ctl.wr_en = 1'b1;
                                waddr         = proc_idx_reg;
                                wdata         = rdata;
                                if (!e_alw)
                                begin
                                    wdata[31:0] = e_time + aux_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    if (rd_idx_reg < count_reg)
                    begin
                        ram_ctl.rd_en   = 1'b1;
                        rd_idx_next     = rd_idx_reg + CW'(1);
                        proc_idx_next   = rd_idx_reg[IW-1:0];
                        proc_valid_next = 1'b1;
                    end
                    else
                    begin
                        proc_valid_next = 1'b0;
                    end

                    if (!proc_valid_reg && !(rd_idx_reg < count_reg))
                    begin
                        state_next = teq_pkg::ST_DONE;
                        case (cmd_reg)
                            teq_pkg::CMD_ADD:
                            begin
                                ram_ctl.wr_en = 1'b1;
                                waddr         = count_reg[IW-1:0];
                                wdata         = hit_reg ? carry_reg
                                                        : {alw_reg, data_reg, hnd_reg, time_reg};
                                count_next    = count_reg + CW'(1);
                            end
                            teq_pkg::CMD_REM_H, teq_pkg::CMD_REM_HD, teq_pkg::CMD_TICK:
                            begin
                                count_next = wr_idx_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            teq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if ((cmd_reg == teq_pkg::CMD_TICK) && pend_valid_reg)
                    begin
                        out_kind = 1'b0;
                        out_h    = pend_h_reg;
                        out_d    = pend_d_reg;
                    end
                    else
                    begin
                        out_found = hit_reg && ((cmd_reg == teq_pkg::CMD_REM_H)
                                    || (cmd_reg == teq_pkg::CMD_REM_HD)
                                    || (cmd_reg == teq_pkg::CMD_FIND));
                        out_delay = delay_reg;
                        out_full  = full_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = teq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_h32 = 32'(out_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= teq_pkg::ST_IDLE;
            count_reg      <= '0;
            depth_reg      <= '0;
            paused_at_reg  <= '0;
            proc_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            depth_reg      <= depth_next;
            paused_at_reg  <= paused_at_next;
            proc_valid_reg <= proc_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        time_reg     <= time_next;
        hnd_reg      <= hnd_next;
        data_reg     <= data_next;
        alw_reg      <= alw_next;
        aux_reg      <= aux_next;
        rd_idx_reg   <= rd_idx_next;
        proc_idx_reg <= proc_idx_next;
        wr_idx_reg   <= wr_idx_next;
        hit_reg      <= hit_next;
        delay_reg    <= delay_next;
        full_reg     <= full_next;
        carry_reg    <= carry_next;
        pend_h_reg   <= pend_h_next;
        pend_d_reg   <= pend_d_next;
        if (out_load)
        begin
            m_kind_reg  <= out_kind;
            m_last_reg  <= out_last;
            m_tdata_reg <= {7'd0, out_full, out_delay, out_found, out_d, out_h32[15:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `TEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_MAX, "entry count above depth")
    `TEQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != teq_pkg::ST_IDLE, "request accepted without leaving idle")
    `TEQ_ASSERT_ALWAYS(a_wr_behind_rd, (state_reg != teq_pkg::ST_WALK) || (wr_idx_reg <= rd_idx_reg), "compaction write overtook read")

endmodule

### src/teq_ram.sv
// ----------------------------------------------------------------------------
// teq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module teq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 81
) (
    input  logic                     clk,
    input  teq_pkg::ram_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
